// ----- rtl/asl_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// asl_pkg
// Shared types and constants of the array subscript linearizer.
// ---------------------------------------------------------------------------
package asl_pkg;

    localparam int NUM_SIZE_REGS = 4;
    localparam int CNT_W         = $clog2(NUM_SIZE_REGS);
    localparam int DIMS_W        = 3;
    localparam int SUB_W         = 12;
    localparam int IDX_W         = 21;
    localparam int STAT_W        = 3;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 12;
    localparam int S_DATA_W      = 56;
    localparam int M_DATA_W      = 24;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ARRAY_DIMS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DIM0_SIZE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DIM3_SIZE  = 3'd4;

    // status codes
    localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
    localparam logic [STAT_W-1:0] ST_NOT_ARRAY = 3'd1;
    localparam logic [STAT_W-1:0] ST_INVALID   = 3'd2;
    localparam logic [STAT_W-1:0] ST_OOB       = 3'd3;
    localparam logic [STAT_W-1:0] ST_TOO_BIG   = 3'd4;

    typedef struct packed {
        logic zero_sub;
        logic over_size;
    } t_lane_flags;

    typedef struct packed {
        logic not_array;
        logic too_big;
        logic depth_bad;
    } t_shape_chk;

endpackage

// ----- rtl/asl_shape_seq.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// asl_shape_seq
// Derives the row-major strides and the saturated element count from the
// configured shape, one dimension per cycle on a shared multiplier.
// ---------------------------------------------------------------------------
module asl_shape_seq
    import asl_pkg::*;
#(
    parameter int MAX_ELEMENTS = 1048576,
    parameter int PROD_W       = 22
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic [DIMS_W-1:0]       i_dims,
    input  logic [SUB_W-1:0]        i_size [NUM_SIZE_REGS],
    output logic                    o_busy,
    output logic [PROD_W-1:0]       o_stride [NUM_SIZE_REGS],
    output logic [PROD_W-1:0]       o_total
);

    localparam int MUL_W = PROD_W + SUB_W;

    logic                r_busy;
    logic [CNT_W-1:0]    r_cnt;
    logic [PROD_W-1:0]   r_acc;
    logic [PROD_W-1:0]   r_total;
    logic [PROD_W-1:0]   r_stride [NUM_SIZE_REGS];

    logic [CNT_W-1:0]    w_k;
    logic [SUB_W-1:0]    w_eff;
    logic [MUL_W-1:0]    w_prod;
    logic [PROD_W-1:0]   n_acc;
    logic                w_last;

    // walk from the least significant dimension up
    assign w_k    = CNT_W'(NUM_SIZE_REGS - 1) - r_cnt;
    assign w_last = (r_cnt == CNT_W'(NUM_SIZE_REGS - 1));

    always_comb begin
        // dimensions beyond the configured count act as size one
        if ({{(DIMS_W-CNT_W){1'b0}}, w_k} < i_dims) begin
            w_eff = i_size[w_k];
        end else begin
            w_eff = SUB_W'(1);
        end
        w_prod = MUL_W'(r_acc) * MUL_W'(w_eff);
        if (w_prod > MUL_W'(MAX_ELEMENTS)) begin
            n_acc = PROD_W'(MAX_ELEMENTS + 1);
        end else begin
            n_acc = w_prod[PROD_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + CNT_W'(1);
            if (w_last) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_start) begin
            r_acc <= PROD_W'(1);
        end else if (r_busy) begin
            r_acc         <= n_acc;
            r_stride[w_k] <= r_acc;
            if (w_last) begin
                r_total <= n_acc;
            end
        end
    end

    assign o_busy   = r_busy;
    assign o_stride = r_stride;
    assign o_total  = r_total;

endmodule

// ----- rtl/asl_lane.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// asl_lane
// One subscript lane: range checks and the weighted term of its dimension.
// ---------------------------------------------------------------------------
module asl_lane
    import asl_pkg::*;
#(
    parameter int PROD_W = 22
) (
    input  logic                i_clk,
    input  logic                i_en,
    input  logic                i_used,
    input  logic [SUB_W-1:0]    i_sub,
    input  logic [SUB_W-1:0]    i_size,
    input  logic [PROD_W-1:0]   i_stride,
    output logic [PROD_W-1:0]   o_term,
    output t_lane_flags         o_flags
);

    localparam int MUL_W = PROD_W + SUB_W;

    logic [PROD_W-1:0]  r_term;
    t_lane_flags        r_flags;
    logic [SUB_W-1:0]   w_sub_m1;
    logic [MUL_W-1:0]   w_prod;
    t_lane_flags        n_flags;
    logic [PROD_W-1:0]  n_term;

    always_comb begin
        w_sub_m1          = i_sub - SUB_W'(1);
        w_prod            = MUL_W'(w_sub_m1) * MUL_W'(i_stride);
        n_flags.zero_sub  = i_used && (i_sub == '0);
        n_flags.over_size = i_used && (i_sub > i_size);
        // only meaningful when every check passes, then it stays below the total
        n_term            = i_used ? w_prod[PROD_W-1:0] : '0;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_term  <= n_term;
            r_flags <= n_flags;
        end
    end

    assign o_term  = r_term;
    assign o_flags = r_flags;

endmodule

// ----- rtl/asl_merge.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// asl_merge
// Combines the lane results into status and linear index, and holds the
// result beat in the output register.
// ---------------------------------------------------------------------------
module asl_merge
    import asl_pkg::*;
#(
    parameter int PROD_W = 22
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic [PROD_W-1:0]   i_terms [NUM_SIZE_REGS],
    input  t_lane_flags         i_flags [NUM_SIZE_REGS],
    input  t_shape_chk          i_shape,
    input  logic                i_ready,
    output logic                o_ready,
    output logic                o_valid,
    output logic [IDX_W-1:0]    o_linear_index,
    output logic [STAT_W-1:0]   o_status
);

    logic                       r_valid;
    logic [IDX_W-1:0]           r_linear_index;
    logic [STAT_W-1:0]          r_status;

    logic                       w_any_zero;
    logic                       w_any_over;
    logic [PROD_W-1:0]          w_sum;
    logic [PROD_W+IDX_W-1:0]    w_sum_ext;
    logic [STAT_W-1:0]          n_status;
    logic [IDX_W-1:0]           n_linear_index;

    always_comb begin
        w_any_zero = 1'b0;
        w_any_over = 1'b0;
        w_sum      = PROD_W'(1);
        for (int i = 0; i < NUM_SIZE_REGS; i++) begin
            w_any_zero = w_any_zero | i_flags[i].zero_sub;
            w_any_over = w_any_over | i_flags[i].over_size;
            w_sum      = w_sum + i_terms[i];
        end
        w_sum_ext = {{IDX_W{1'b0}}, w_sum};

        priority if (i_shape.not_array) begin
            n_status = ST_NOT_ARRAY;
        end else if (i_shape.too_big) begin
            n_status = ST_TOO_BIG;
        end else if (i_shape.depth_bad || w_any_zero) begin
            n_status = ST_INVALID;
        end else if (w_any_over) begin
            n_status = ST_OOB;
        end else begin
            n_status = ST_OK;
        end

        n_linear_index = (n_status == ST_OK) ? w_sum_ext[IDX_W-1:0] : '0;
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_linear_index <= n_linear_index;
            r_status       <= n_status;
        end
    end

    assign o_valid        = r_valid;
    assign o_linear_index = r_linear_index;
    assign o_status       = r_status;

endmodule

// ----- rtl/array_subscript_linearizer_top.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// array_subscript_linearizer_top
// Turns a 1-based subscript of up to four dimensions into a 1-based
// row-major element number, checked against the configured array shape.
// ---------------------------------------------------------------------------
// One access beat is accepted per clock while the sequencer is idle and the
// output is not stalled; its result passes the lane register, then the output
// register. Results leave in order and a stalled output holds while one more
// access waits in the lane stage. Four parallel lanes check and weight one
// subscript each and a merge stage adds the terms and picks the status. Strides
// and the element count come from a sequencer with one multiplier that takes
// one dimension per cycle: after reset and after every configuration write the
// input is held off while it runs. Configuration writes are always taken.
module array_subscript_linearizer_top
    import asl_pkg::*;
#(
    parameter int MAX_DIMS     = 4,
    parameter int MAX_ELEMENTS = 1048576
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // config write channel
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [CFG_DATA_W-1:0]   i_cfg_data,
    // access beats
    input  logic                    i_s_axis_tvalid,
    output logic                    o_s_axis_tready,
    // given_depth[2:0], sub0[14:3], sub1[26:15], sub2[38:27], sub3[50:39], zero pad
    input  logic [S_DATA_W-1:0]     i_s_axis_tdata,
    // result beats
    output logic                    o_m_axis_tvalid,
    input  logic                    i_m_axis_tready,
    // linear_index[20:0], status[23:21]
    output logic [M_DATA_W-1:0]     o_m_axis_tdata
);

    localparam int PROD_W     = $clog2(MAX_ELEMENTS + 1) + 1;
    localparam int DIMS_LIMIT = (MAX_DIMS < NUM_SIZE_REGS) ? MAX_DIMS : NUM_SIZE_REGS;

    logic [DIMS_W-1:0]  r_dims;
    logic [SUB_W-1:0]   r_size [NUM_SIZE_REGS];
    logic               r_v1;
    t_shape_chk         r_shape;
    t_shape_chk         n_shape;

    logic               w_cfg_wr;
    logic               w_s_acc;
    logic               w_st1_en;
    logic               w_st2_ready;
    logic               w_seq_busy;
    logic [PROD_W-1:0]  w_stride [NUM_SIZE_REGS];
    logic [PROD_W-1:0]  w_total;
    logic [DIMS_W-1:0]  w_depth;
    logic [SUB_W-1:0]   w_sub [NUM_SIZE_REGS];
    logic [PROD_W-1:0]  w_terms [NUM_SIZE_REGS];
    t_lane_flags        w_flags [NUM_SIZE_REGS];
    logic [IDX_W-1:0]   w_linear_index;
    logic [STAT_W-1:0]  w_status;

    // config registers
    assign o_cfg_ready = 1'b1;
    assign w_cfg_wr    = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dims <= '0;
            for (int i = 0; i < NUM_SIZE_REGS; i++) begin
                r_size[i] <= SUB_W'(1);
            end
        end else if (w_cfg_wr) begin
            if (i_cfg_index == REG_ARRAY_DIMS) begin
                r_dims <= i_cfg_data[DIMS_W-1:0];
            end else if (i_cfg_index >= REG_DIM0_SIZE && i_cfg_index <= REG_DIM3_SIZE) begin
                r_size[CNT_W'(i_cfg_index - REG_DIM0_SIZE)] <= i_cfg_data[SUB_W-1:0];
            end
        end
    end

    asl_shape_seq #(
        .MAX_ELEMENTS (MAX_ELEMENTS),
        .PROD_W       (PROD_W)
    ) u_shape_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_cfg_wr),
        .i_dims   (r_dims),
        .i_size   (r_size),
        .o_busy   (w_seq_busy),
        .o_stride (w_stride),
        .o_total  (w_total)
    );

    // input beat unpack
    assign w_depth = i_s_axis_tdata[DIMS_W-1:0];
    for (genvar g = 0; g < NUM_SIZE_REGS; g++) begin : g_unpack
        assign w_sub[g] = i_s_axis_tdata[DIMS_W + g*SUB_W +: SUB_W];
    end

    assign w_st1_en        = !r_v1 || w_st2_ready;
    assign o_s_axis_tready = !w_seq_busy && w_st1_en;
    assign w_s_acc         = i_s_axis_tvalid && o_s_axis_tready;

    always_comb begin
        n_shape.not_array = (r_dims == '0) || (r_dims > DIMS_W'(DIMS_LIMIT));
        n_shape.too_big   = (w_total > PROD_W'(MAX_ELEMENTS));
        n_shape.depth_bad = (w_depth != r_dims);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (w_st1_en) begin
            r_v1 <= w_s_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s_acc) begin
            r_shape <= n_shape;
        end
    end

    for (genvar g = 0; g < NUM_SIZE_REGS; g++) begin : g_lane
        asl_lane #(
            .PROD_W (PROD_W)
        ) u_lane (
            .i_clk    (i_clk),
            .i_en     (w_s_acc),
            .i_used   (DIMS_W'(g) < r_dims),
            .i_sub    (w_sub[g]),
            .i_size   (r_size[g]),
            .i_stride (w_stride[g]),
            .o_term   (w_terms[g]),
            .o_flags  (w_flags[g])
        );
    end

    asl_merge #(
        .PROD_W (PROD_W)
    ) u_merge (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (r_v1),
        .i_terms        (w_terms),
        .i_flags        (w_flags),
        .i_shape        (r_shape),
        .i_ready        (i_m_axis_tready),
        .o_ready        (w_st2_ready),
        .o_valid        (o_m_axis_tvalid),
        .o_linear_index (w_linear_index),
        .o_status       (w_status)
    );

    assign o_m_axis_tdata = {w_status, w_linear_index};

`ifndef SYNTHESIS
    // a config write restarts the stride sequencer, so no beat is taken next cycle
    a_cfg_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cfg_wr |=> !o_s_axis_tready)
        else $error("access accepted right after a config write");

    // an accepted beat always lands in the lane stage
    a_accept_fills_lane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_s_acc |=> r_v1)
        else $error("accepted beat lost before the lane stage");

    // a failed access never carries an element number
    a_fail_zero_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && w_status != ST_OK) |-> (w_linear_index == '0))
        else $error("nonzero index with failing status");

    a_status_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (w_status <= ST_TOO_BIG))
        else $error("undefined status code");
`endif

endmodule
